// ===== design/psbk_pkg.sv =====
`default_nettype none
package psbk_pkg;

   localparam int MAX_ITEMS_DEF = 64;
   localparam int WORD_W        = 32;
   localparam int PAIR_W        = 2 * WORD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   typedef struct packed {
      logic accept;
      logic set_ovf;
      logic ins_rd;
      logic write_new;
      logic shift;
      logic count_inc;
      logic out_rd;
      logic out_next;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_full;
      logic pos_zero;
      logic key_le;
      logic item_last;
      logic out_last;
   } ctrl_sts_type;

endpackage
`default_nettype wire

// ===== design/psbk_dp.sv =====
`default_nettype none
module psbk_dp #(
   parameter int MAX_ITEMS = psbk_pkg::MAX_ITEMS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  psbk_pkg::ctrl_cmd_type  cmd,
   output psbk_pkg::ctrl_sts_type        sts,
   input  wire  [psbk_pkg::WORD_W-1:0]   in_payload,
   input  wire  [psbk_pkg::WORD_W-1:0]   in_key,
   input  wire                           in_last,
   output logic [psbk_pkg::PAIR_W-1:0]   out_pair,
   output logic                          out_final,
   output logic                          out_ovf
);
   import psbk_pkg::*;

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);

   // Each store entry holds the key in the upper word and the payload in the lower.
   logic [PAIR_W-1:0] mem_ff [MAX_ITEMS];
   logic [PAIR_W-1:0] rd_data_ff;

   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic              ovf_ff, ovf_in;
   logic [WORD_W-1:0] item_pay_ff, item_key_ff;
   logic              item_last_ff;

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [PAIR_W-1:0] wr_data;

   assign rd_en   = cmd.ins_rd | cmd.out_rd;
   assign rd_addr = cmd.ins_rd ? (pos_ff - AW'(1)) : idx_ff;
   assign wr_en   = cmd.write_new | cmd.shift;
   assign wr_data = cmd.write_new ? {item_key_ff, item_pay_ff} : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[pos_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (cmd.accept) begin
         item_pay_ff  <= in_payload;
         item_key_ff  <= in_key;
         item_last_ff <= in_last;
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      idx_in   = idx_ff;
      ovf_in   = ovf_ff;
      if (cmd.accept) begin
         pos_in = count_ff[AW-1:0];
         idx_in = '0;
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.shift) begin
         pos_in = pos_ff - AW'(1);
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.out_next) begin
         idx_in = idx_ff + AW'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
         idx_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
         idx_ff   <= idx_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_comb begin
      sts.count_full = (count_ff == CW'(MAX_ITEMS));
      sts.pos_zero   = (pos_ff == '0);
      sts.key_le     = ($signed(rd_data_ff[PAIR_W-1:WORD_W]) <= $signed(item_key_ff));
      sts.item_last  = item_last_ff;
      sts.out_last   = ((CW'(idx_ff) + CW'(1)) == count_ff);
   end

   assign out_pair  = rd_data_ff;
   assign out_final = sts.out_last;
   assign out_ovf   = ovf_ff;

endmodule
`default_nettype wire

// ===== design/psbk_ctrl.sv =====
`default_nettype none
module psbk_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   input  wire                           req_tlast,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output psbk_pkg::ctrl_cmd_type        cmd,
   input  wire  psbk_pkg::ctrl_sts_type  sts
);
   import psbk_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!sts.count_full) begin
                  state_in = ST_INS_RD;
               end else if (req_tlast) begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (sts.pos_zero) begin
               state_in = sts.item_last ? ST_OUT_RD : ST_IDLE;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (sts.key_le) begin
               state_in = sts.item_last ? ST_OUT_RD : ST_IDLE;
            end else begin
               state_in = ST_INS_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_tready) begin
               state_in = sts.out_last ? ST_IDLE : ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.accept  = req_tvalid;
            cmd.set_ovf = req_tvalid & sts.count_full;
         end
         ST_INS_RD: begin
            // An empty slot at the bottom of the store takes the new pair at once.
            if (sts.pos_zero) begin
               cmd.write_new = 1'b1;
               cmd.count_inc = 1'b1;
            end else begin
               cmd.ins_rd = 1'b1;
            end
         end
         ST_INS_CMP: begin
            if (sts.key_le) begin
               cmd.write_new = 1'b1;
               cmd.count_inc = 1'b1;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
         end
         ST_OUT_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.clear    = sts.out_last;
               cmd.out_next = ~sts.out_last;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/pair_sort_by_key_top.sv =====
`default_nettype none
// Input: a word is taken while idle, then inserted by reading and comparing each held pair with a
// greater key and shifting it up a slot (a word landing at the bottom is written without compare);
// a word that arrives while the store is full is dropped and sets the overflow flag. Output: after
// the last word is inserted or dropped, each result is read from the store, then handed over once
// rsp_tready is high. Reset clears the state machine, the fill count and the overflow flag;
// store contents are left as they are and are never read before being written.
module pair_sort_by_key_top #(
   parameter int MAX_ITEMS = psbk_pkg::MAX_ITEMS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire  [psbk_pkg::PAIR_W-1:0]    req_tdata,   // payload [31:0], sort_key [63:32]
   input  wire                            req_tlast,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [psbk_pkg::PAIR_W-1:0]    rsp_tdata,   // out_payload [31:0], out_key [63:32]
   output logic                           rsp_tlast,
   output logic [0:0]                     rsp_tuser    // overflowed [0]
);
   import psbk_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic         ovf;

   psbk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   psbk_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_payload (req_tdata[WORD_W-1:0]),
      .in_key     (req_tdata[PAIR_W-1:WORD_W]),
      .in_last    (req_tlast),
      .out_pair   (rsp_tdata),
      .out_final  (rsp_tlast),
      .out_ovf    (ovf)
   );

   assign rsp_tuser = ovf;

endmodule
`default_nettype wire
